### rtl/ordered_list_engine_unit_macros.svh
// assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define OLE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered list engine check failed");
// next-cycle implication, checked outside reset
`define OLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list engine check failed");
`else
`define OLE_ASSERT_NOW(label, clk, rst, ante, cons)
`define OLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/ole_pkg.sv
// types and codes shared by the ordered list engine
package ole_pkg;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_SEARCH = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // what the cell row does at the next edge
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_APPEND,
    MODE_INSERT,
    MODE_DELETE
  } ole_mode_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic [4:0]         position;
  } ole_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_index;
    logic [4:0] entry_count;
  } ole_result_t;

endpackage

### rtl/ole_cell.sv
// one list cell: holds one entry, compares it and shifts with its neighbors
module ole_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 5,
  parameter int XW         = 5
) (
  input  logic                  clk,
  input  ole_pkg::ole_mode_t    mode,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [CW-1:0]         count,
  input  logic [XW-1:0]         pos,
  input  logic [DATA_WIDTH-1:0] prev_word,
  input  logic [DATA_WIDTH-1:0] next_word,
  input  logic                  hit_in,
  output logic [DATA_WIDTH-1:0] word,
  output logic                  hit_out,
  output logic                  first
);
  import ole_pkg::*;

  logic valid;
  logic match;

  // compare against the key, pass the hit chain on
  assign valid   = CW'(IDX) < count;
  assign match   = valid && (word == key);
  assign hit_out = hit_in || match;
  assign first   = match && !hit_in;

  // entry update
  always_ff @(posedge clk) begin
    unique case (mode)
      MODE_APPEND: begin
        if (CW'(IDX) == count) word <= key;
      end
      MODE_INSERT: begin
        if (XW'(IDX) == pos) word <= key;
        else if (XW'(IDX) > pos) word <= prev_word;
      end
      MODE_DELETE: begin
        if (hit_out) word <= next_word;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/ordered_list_engine_unit.sv
// ordered list engine top level: command decode, count and cell row
//
// Keeps an ordered list of up to CAPACITY words in a row of cells, one entry
// per cell. A command beat (append, insert at position, delete by value,
// search) is taken at a clock edge with start high and busy low; busy is
// never raised, so one command is taken every cycle.
// All cells compare their entry with the value at once, and a one-bit hit
// chain running through the row picks the first match. Insert and delete
// shift entries one place between neighboring cells at the same edge.
// The result beat (status, found_index, entry_count) appears with done high
// for exactly one cycle, the cycle after the command is taken, so results
// come at one command per cycle. The hit chain through all cells sets the
// cycle time.
// The receiver cannot stall; it must take each result beat when done is high.
// Reset (rst, synchronous) empties the list and clears done; entry contents
// are left as they are and are never read until written again.
module ordered_list_engine_unit #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ole_pkg::ole_cmd_t    command,
  output logic                 done,
  output ole_pkg::ole_result_t result
);
  import ole_pkg::*;

  `include "ordered_list_engine_unit_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [DATA_WIDTH-1:0] key;
  logic [XW-1:0]         pos_ext;
  logic                  accept;
  logic                  full;
  logic                  any_hit;
  ole_mode_t             mode;
  logic [1:0]            status_next;
  logic [3:0]            index_next;
  logic [3:0]            found_or;

  logic [DATA_WIDTH-1:0] words [CAPACITY];
  logic                  hit   [CAPACITY+1];
  logic                  first [CAPACITY];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign key     = DATA_WIDTH'(unsigned'(command.value));
  assign pos_ext = XW'(command.position);
  assign full    = count == CW'(CAPACITY);
  assign hit[0]  = 1'b0;
  assign any_hit = hit[CAPACITY];

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w;
    logic [DATA_WIDTH-1:0] next_w;
    assign prev_w = (i == 0) ? words[i] : words[(i == 0) ? 0 : i - 1];
    assign next_w = (i == CAPACITY - 1) ? words[i]
                                        : words[(i == CAPACITY - 1) ? i : i + 1];
    ole_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .XW         (XW)
    ) u_cell (
      .clk       (clk),
      .mode      (mode),
      .key       (key),
      .count     (count),
      .pos       (pos_ext),
      .prev_word (prev_w),
      .next_word (next_w),
      .hit_in    (hit[i]),
      .word      (words[i]),
      .hit_out   (hit[i+1]),
      .first     (first[i])
    );
  end

  // index of the first matching cell
  always_comb begin
    found_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) found_or = found_or | 4'(i);
    end
  end

  // command decode
  always_comb begin
    mode        = MODE_HOLD;
    status_next = ST_OK;
    index_next  = '0;
    count_next  = count;
    unique case (command.cmd)
      CMD_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          mode       = MODE_APPEND;
          count_next = count + CW'(1);
        end
      end
      CMD_INSERT: begin
        if (pos_ext > XW'(count)) begin
          status_next = ST_BAD_POS;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          mode       = MODE_INSERT;
          count_next = count + CW'(1);
        end
      end
      CMD_DELETE: begin
        mode = MODE_DELETE;
        if (any_hit) begin
          count_next = count - CW'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        if (any_hit) begin
          index_next = found_or;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
    endcase
    if (!accept) begin
      mode       = MODE_HOLD;
      count_next = count;
    end
  end

  // count and done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (accept) begin
      result.status      <= status_next;
      result.found_index <= index_next;
      result.entry_count <= 5'(count_next);
    end
  end

  `OLE_ASSERT_NEXT(a_done_follows, clk, rst, accept, done)
  `OLE_ASSERT_NEXT(a_no_stray_done, clk, rst, !accept, !done)
  `OLE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `OLE_ASSERT_NOW(a_full_status, clk, rst, done && result.status == ST_FULL, full)
  `OLE_ASSERT_NOW(a_count_step, clk, rst, !$past(rst),
    (count == $past(count)) || (count == $past(count) + CW'(1)) ||
    (count == $past(count) - CW'(1)))

endmodule

### dv/ordered_list_engine_unit_tb.sv
// testbench for the ordered list engine: directed and random command beats checked per result
module ordered_list_engine_unit_tb;
  import ole_pkg::*;

  // tracks the list contents and the results still owed by the block
  class list_scoreboard;
    localparam int DEPTH = 16;

    logic [31:0]  cells [DEPTH];
    int unsigned  fill;
    ole_result_t  owed_q [$];
    int unsigned  errors;

    // apply one command to the list copy and return the result it should give
    function ole_result_t apply_command(ole_cmd_t c);
      ole_result_t r;
      int unsigned hit;
      int unsigned i;
      r.status = ST_OK;
      r.found_index = '0;
      // first entry equal to the value, or fill when absent
      hit = fill;
      for (i = 0; i < fill; i++) begin
        if (hit == fill && cells[i] == c.value) begin
          hit = i;
        end
      end
      case (c.cmd)
        CMD_APPEND: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            cells[fill] = c.value;
            fill++;
          end
        end
        CMD_INSERT: begin
          // a bad position wins over a full list
          if (c.position > fill) begin
            r.status = ST_BAD_POS;
          end else if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > c.position; i--) begin
              cells[i] = cells[i - 1];
            end
            cells[c.position] = c.value;
            fill++;
          end
        end
        CMD_DELETE: begin
          if (hit == fill) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (i = hit; i + 1 < fill; i++) begin
              cells[i] = cells[i + 1];
            end
            fill--;
          end
        end
        default: begin
          if (hit == fill) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.found_index = hit[3:0];
          end
        end
      endcase
      r.entry_count = fill[4:0];
      return r;
    endfunction

    // accepted command beat
    function void note_command(ole_cmd_t c);
      owed_q.push_back(apply_command(c));
    endfunction

    // result beat against the oldest owed result
    function void check_result(ole_result_t got);
      ole_result_t want;
      if (owed_q.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.found_index !== want.found_index) begin
        $error("found_index mismatch: expected %0d, actual %0d",
               want.found_index, got.found_index);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count mismatch: expected %0d, actual %0d",
               want.entry_count, got.entry_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  localparam int RANDOM_BEATS = 1500;
  localparam int CALM_TAIL    = 200;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  ole_cmd_t    command;
  logic        done;
  ole_result_t result;

  list_scoreboard sb = new();
  logic [31:0]    value_pool [8];

  ordered_list_engine_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watch both sides at every edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_result(result);
      end
      if (start && !busy) begin
        sb.note_command(command);
      end
    end
  end

  // drive one command beat, hold it until taken, then maybe go quiet for a burst
  task automatic issue(input logic [1:0] op, input logic [31:0] v, input logic [4:0] p,
                       input int idle_pct);
    ole_cmd_t c;
    c.cmd = op;
    c.value = v;
    c.position = p;
    start <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // mostly values that recur so deletes and searches hit
  function automatic logic [31:0] pick_value(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) begin
      return value_pool[$urandom_range(0, 7)];
    end
    return $urandom();
  endfunction

  initial begin
    int          n;
    int          phase_left;
    int          idle_pct;
    int          gap_pct;
    int          roll;
    bit          growing;
    logic [1:0]  op;
    logic [4:0]  pos;

    rst = 1'b1;
    start = 1'b0;
    command = '0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (n = 4; n < 8; n++) begin
      value_pool[n] = $urandom();
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list: search and delete miss, insert past the end is rejected
    issue(CMD_SEARCH, 32'h7fff_ffff, 5'd0, 20);
    issue(CMD_DELETE, 32'h8000_0000, 5'd0, 20);
    issue(CMD_INSERT, 32'h1234_5678, 5'd1, 20);
    issue(CMD_INSERT, 32'hdead_beef, 5'd31, 20);
    // build a short list with extremes, insert at head, tail and middle
    issue(CMD_INSERT, 32'h8000_0000, 5'd0, 20);
    issue(CMD_APPEND, 32'h7fff_ffff, 5'd0, 20);
    issue(CMD_APPEND, 32'h0000_0000, 5'd0, 20);
    issue(CMD_APPEND, 32'hffff_ffff, 5'd0, 20);
    issue(CMD_INSERT, 32'hffff_ffff, 5'd4, 20);
    issue(CMD_INSERT, 32'h5555_5555, 5'd2, 20);
    issue(CMD_SEARCH, 32'h7fff_ffff, 5'd0, 20);
    // duplicate value: delete takes the first one
    issue(CMD_DELETE, 32'hffff_ffff, 5'd0, 20);
    // fill to capacity
    for (n = 0; n < 11; n++) begin
      issue(CMD_APPEND, 32'h0000_1000 + n, 5'(n), 20);
    end
    // full list: append and valid insert report full, bad position wins
    issue(CMD_APPEND, 32'haaaa_aaaa, 5'd0, 20);
    issue(CMD_INSERT, 32'haaaa_aaaa, 5'd3, 20);
    issue(CMD_INSERT, 32'haaaa_aaaa, 5'd17, 20);
    issue(CMD_SEARCH, 32'h0000_100a, 5'd0, 20);

    // let the block drain completely before the random part
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);

    // random part: alternating grow and shrink phases with varying idle density
    growing = 1'b0;
    phase_left = 0;
    idle_pct = 0;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (phase_left == 0) begin
        growing = !growing;
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 12;
          default: idle_pct = 35;
        endcase
      end
      phase_left--;
      gap_pct = (n >= RANDOM_BEATS - CALM_TAIL) ? 0 : idle_pct;

      // sender holds off once until every owed result is in
      if (n == RANDOM_BEATS / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end

      roll = $urandom_range(0, 99);
      if (growing) begin
        op = (roll < 45) ? CMD_APPEND : (roll < 80) ? CMD_INSERT :
             (roll < 90) ? CMD_DELETE : CMD_SEARCH;
      end else begin
        op = (roll < 55) ? CMD_DELETE : (roll < 80) ? CMD_SEARCH :
             (roll < 90) ? CMD_APPEND : CMD_INSERT;
      end
      // positions mostly within the list, sometimes anywhere in the field
      if ($urandom_range(0, 99) < 75) begin
        pos = 5'($urandom_range(0, sb.fill));
      end else begin
        pos = 5'($urandom_range(0, 31));
      end
      if (op == CMD_APPEND || op == CMD_INSERT) begin
        issue(op, pick_value(70), pos, gap_pct);
      end else begin
        issue(op, pick_value(80), pos, gap_pct);
      end
    end

    // wind down and wait for the last result beats
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### ordered_list_engine_unit.f
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_cell.sv
rtl/ordered_list_engine_unit.sv
dv/ordered_list_engine_unit_tb.sv
